// File: src/hex_cell_from_point_defines.svh
// Assertion macros for the hexagon cell lookup block
`ifndef HEX_CELL_FROM_POINT_DEFINES_SVH
`define HEX_CELL_FROM_POINT_DEFINES_SVH

// Check a consequence in the same cycle as its antecedent
`define HCFP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Check a consequence in the cycle after its antecedent
`define HCFP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/hcfp_pkg.sv
// Shared types, constants and helpers for the hexagon cell lookup block
`timescale 1ns / 1ps
`default_nettype none
package hcfp_pkg;

  // sqrt(3) in Q1.14
  localparam logic [14:0] SQRT3_Q14   = 15'd28378;
  localparam logic [6:0]  MAX_ROWS    = 7'd64;
  localparam logic [6:0]  MAX_COLUMNS = 7'd64;

  // Quotient bits of each division, and pipeline depth
  localparam int DIV_STEPS = 8;
  localparam int NUM_STG   = DIV_STEPS + 4;

  // Remainder and product widths
  localparam int REM_H_W = 24;
  localparam int REM_K_W = 39;
  localparam int PROD_W  = 31;

  // Configuration register indexes
  localparam logic [2:0] REG_ORIGIN_X       = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y       = 3'd1;
  localparam logic [2:0] REG_SIDE_LENGTH    = 3'd2;
  localparam logic [2:0] REG_ROW_COUNT      = 3'd3;
  localparam logic [2:0] REG_LONG_ROW_CELLS = 3'd4;
  localparam logic [2:0] REG_FIRST_ROW_LONG = 3'd5;

  typedef struct packed {
    logic signed [11:0] point_x;
    logic signed [11:0] point_y;
  } in_t;

  typedef struct packed {
    logic        hit;
    logic [11:0] cell_index;
    logic [5:0]  cell_row;
    logic [5:0]  cell_column;
  } out_t;

  // Division pipeline payload
  typedef struct packed {
    logic               miss;
    logic [7:0]         qh;
    logic [7:0]         qk;
    logic [REM_H_W-1:0] rem_h;
    logic [REM_K_W-1:0] rem_k;
  } div_t;

  // Slope stage payload
  typedef struct packed {
    logic              miss;
    logic [6:0]        band;
    logic              zig;
    logic [7:0]        k;
    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] rem_k;
  } slope_t;

  // Selected cell
  typedef struct packed {
    logic       hit;
    logic [5:0] row;
    logic [5:0] col;
  } sel_t;

  // Clamp a row or column register to its maximum
  function automatic logic [6:0] sat7(input logic [6:0] v, input logic [6:0] lim);
    sat7 = (v > lim) ? lim : v;
  endfunction

endpackage
`default_nettype wire

// File: src/hcfp_front.sv
// Entry stage: offsets from the grid corner, range checks and divider seeds
`timescale 1ns / 1ps
`default_nettype none
module hcfp_front (
  input  wire logic                clk,
  input  wire logic                en,
  input  wire hcfp_pkg::in_t       in_data,
  input  wire logic signed [11:0]  origin_x,
  input  wire logic signed [11:0]  origin_y,
  input  wire logic [15:0]         side,
  input  wire logic [30:0]         dmul,
  output hcfp_pkg::div_t           q_r
);

  logic signed [12:0] dx, dy;
  logic [hcfp_pkg::REM_H_W-1:0] ny, lim_h;
  logic [hcfp_pkg::REM_K_W-1:0] nx, lim_k;
  hcfp_pkg::div_t q_nxt;

  // Form offsets and scaled dividends
  always_comb begin
    dx    = {in_data.point_x[11], in_data.point_x} - {origin_x[11], origin_x};
    dy    = {in_data.point_y[11], in_data.point_y} - {origin_y[11], origin_y};
    ny    = {3'b0, dy[11:0], 9'b0};
    nx    = {4'b0, dx[11:0], 23'b0};
    lim_h = {side, 8'b0};
    lim_k = {dmul, 8'b0};
    q_nxt.miss  = dx[12] | dy[12] | (side == 16'd0) | (ny >= lim_h) | (nx >= lim_k);
    q_nxt.qh    = 8'd0;
    q_nxt.qk    = 8'd0;
    q_nxt.rem_h = ny;
    q_nxt.rem_k = nx;
  end

  // Advance when the stage moves
  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= q_nxt;
    end
  end

endmodule
`default_nettype wire

// File: src/hcfp_div_step.sv
// One restoring step of both band and half-width divisions
`timescale 1ns / 1ps
`default_nettype none
module hcfp_div_step (
  input  wire logic           clk,
  input  wire logic           en,
  input  wire logic [2:0]     bit_idx,
  input  wire logic [15:0]    side,
  input  wire logic [30:0]    dmul,
  input  wire hcfp_pkg::div_t d,
  output hcfp_pkg::div_t      q_r
);

  logic [hcfp_pkg::REM_H_W-1:0] t_h;
  logic [hcfp_pkg::REM_K_W-1:0] t_k;
  hcfp_pkg::div_t q_nxt;

  // Trial subtract of the shifted divisors
  always_comb begin
    t_h   = {8'b0, side} << bit_idx;
    t_k   = {8'b0, dmul} << bit_idx;
    q_nxt = d;
    if (d.rem_h >= t_h) begin
      q_nxt.rem_h        = d.rem_h - t_h;
      q_nxt.qh[bit_idx]  = 1'b1;
    end
    if (d.rem_k >= t_k) begin
      q_nxt.rem_k        = d.rem_k - t_k;
      q_nxt.qk[bit_idx]  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= q_nxt;
    end
  end

endmodule
`default_nettype wire

// File: src/hcfp_zone.sv
// Slope product stage and row/column selection stage
`timescale 1ns / 1ps
`default_nettype none
module hcfp_zone (
  input  wire logic           clk,
  input  wire logic           en_a,
  input  wire logic           en_b,
  input  wire logic [30:0]    dmul,
  input  wire logic [6:0]     rows,
  input  wire logic [6:0]     cols,
  input  wire logic           first_long,
  input  wire hcfp_pkg::div_t d,
  output hcfp_pkg::sel_t      q_r
);

  hcfp_pkg::slope_t s_r, s_nxt;
  hcfp_pkg::sel_t   q_nxt;
  logic [15:0] b_prod;
  logic [8:0]  b3;
  logic [15:0] rh;

  logic              top_hit, bot_hit, short_b, short_r, k_even, cen_miss;
  logic [hcfp_pkg::PROD_W-1:0] dp;
  logic signed [8:0] bs, bm1, kh, khm1, km1h, row, col;
  logic [7:0]        km1;
  logic [6:0]        ncells;

  // Band group, zig-zag flag and slope product
  always_comb begin
    b_prod      = 16'(d.qh) * 16'd171;
    s_nxt.band  = b_prod[15:9];
    b3          = {1'b0, s_nxt.band, 1'b0} + {2'b0, s_nxt.band};
    s_nxt.zig   = ({1'b0, d.qh} == b3);
    s_nxt.miss  = d.miss;
    s_nxt.k     = d.qk;
    rh          = d.rem_h[15:0];
    s_nxt.prod  = hcfp_pkg::PROD_W'(rh * hcfp_pkg::SQRT3_Q14);
    s_nxt.rem_k = d.rem_k[hcfp_pkg::PROD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      s_r <= s_nxt;
    end
  end

  // Choose row and column, then range-check against the grid
  always_comb begin
    top_hit  = s_r.prod > s_r.rem_k;
    dp       = dmul - s_r.prod;
    bot_hit  = dp > s_r.rem_k;
    bs       = {2'b0, s_r.band};
    bm1      = bs - 9'sd1;
    kh       = {2'b0, s_r.k[7:1]};
    khm1     = kh - 9'sd1;
    km1      = s_r.k - 8'd1;
    km1h     = {2'b0, km1[7:1]};
    k_even   = ~s_r.k[0];
    short_b  = s_r.band[0] ^ ~first_long;
    cen_miss = 1'b0;
    row      = bs;
    col      = kh;
    if (s_r.zig) begin
      if (short_b) begin
        if (k_even) begin
          if (top_hit) begin
            row = bs;  col = khm1;
          end else begin
            row = bm1; col = kh;
          end
        end else begin
          if (bot_hit) begin
            row = bm1; col = kh;
          end else begin
            row = bs;  col = kh;
          end
        end
      end else begin
        if (k_even) begin
          if (bot_hit) begin
            row = bm1; col = khm1;
          end else begin
            row = bs;  col = kh;
          end
        end else begin
          if (top_hit) begin
            row = bs;  col = kh;
          end else begin
            row = bm1; col = kh;
          end
        end
      end
    end else if (short_b) begin
      cen_miss = (s_r.k == 8'd0);
      col      = km1h;
    end
    // A short row with no long-row cells holds nothing
    short_r   = row[0] ^ ~first_long;
    ncells    = short_r ? ((cols == 7'd0) ? 7'd0 : (cols - 7'd1)) : cols;
    q_nxt.hit = ~s_r.miss & ~cen_miss & ~row[8] & ~col[8]
                & (row[7:0] < {1'b0, rows}) & (col[7:0] < {1'b0, ncells});
    q_nxt.row = row[5:0];
    q_nxt.col = col[5:0];
  end

  always_ff @(posedge clk) begin
    if (en_b) begin
      q_r <= q_nxt;
    end
  end

endmodule
`default_nettype wire

// File: src/hcfp_index.sv
// Output stage: linear cell index and cleared fields on a miss
`timescale 1ns / 1ps
`default_nettype none
module hcfp_index (
  input  wire logic           clk,
  input  wire logic           en,
  input  wire logic [6:0]     cols,
  input  wire logic           first_long,
  input  wire hcfp_pkg::sel_t d,
  output hcfp_pkg::out_t      q_r
);

  logic [7:0]  pair_len;
  logic [12:0] base;
  logic [6:0]  odd_off;
  logic [12:0] idx;
  hcfp_pkg::out_t q_nxt;

  // Cells before this row pair, plus the first row of the pair if odd
  always_comb begin
    pair_len = {cols, 1'b0} - 8'd1;
    base     = 13'(pair_len * d.row[5:1]);
    odd_off  = d.row[0] ? (first_long ? cols : (cols - 7'd1)) : 7'd0;
    idx      = base + {7'b0, d.col} + {6'b0, odd_off};
    q_nxt.hit         = d.hit;
    q_nxt.cell_index  = d.hit ? idx[11:0] : 12'd0;
    q_nxt.cell_row    = d.hit ? d.row : 6'd0;
    q_nxt.cell_column = d.hit ? d.col : 6'd0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= q_nxt;
    end
  end

endmodule
`default_nettype wire

// File: src/hex_cell_from_point.sv
// Twelve register stages lie between an accepted transaction and out_valid.
// Throughput: one transaction per cycle while out_ready is high; the eight-step divider pipeline sets depth.
// Each stage advances when empty or when the stage after it moves, so bubbles close up.
// Reset (rst_n low at a clock edge) empties the pipeline and loads the register
// defaults: origins 0, side 5120, 8 rows, 8 cells a long row, row zero short.
`timescale 1ns / 1ps
`default_nettype none
`include "hex_cell_from_point_defines.svh"
module hex_cell_from_point (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire hcfp_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output hcfp_pkg::out_t      out_data,
  input  wire logic           cfg_we,
  input  wire logic [2:0]     cfg_index,
  input  wire logic [15:0]    cfg_wdata
);

  localparam int N = hcfp_pkg::NUM_STG;

  logic signed [11:0] origin_x_r, origin_y_r;
  logic [15:0] side_r;
  logic [6:0]  row_count_r, long_cells_r;
  logic        first_long_r;
  logic [30:0] dmul;
  logic [6:0]  rows_sat, cols_sat;

  logic [N-1:0] v_r, v_nxt;
  logic [N:0]   en;

  hcfp_pkg::div_t div_q [0:hcfp_pkg::DIV_STEPS];
  hcfp_pkg::sel_t sel_q;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r   <= 12'sd0;
      origin_y_r   <= 12'sd0;
      side_r       <= 16'd5120;
      row_count_r  <= 7'd8;
      long_cells_r <= 7'd8;
      first_long_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hcfp_pkg::REG_ORIGIN_X:       origin_x_r   <= cfg_wdata[11:0];
        hcfp_pkg::REG_ORIGIN_Y:       origin_y_r   <= cfg_wdata[11:0];
        hcfp_pkg::REG_SIDE_LENGTH:    side_r       <= cfg_wdata;
        hcfp_pkg::REG_ROW_COUNT:      row_count_r  <= cfg_wdata[6:0];
        hcfp_pkg::REG_LONG_ROW_CELLS: long_cells_r <= cfg_wdata[6:0];
        hcfp_pkg::REG_FIRST_ROW_LONG: first_long_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Form the half-width divisor sqrt(3)*side
  assign dmul = 31'(side_r * hcfp_pkg::SQRT3_Q14);

  assign rows_sat = hcfp_pkg::sat7(row_count_r, hcfp_pkg::MAX_ROWS);
  assign cols_sat = hcfp_pkg::sat7(long_cells_r, hcfp_pkg::MAX_COLUMNS);

  // Stage enables: move when empty or when downstream moves
  always_comb begin
    en[N] = out_ready;
    for (int i = N - 1; i >= 0; i--) begin
      en[i] = ~v_r[i] | en[i+1];
    end
    v_nxt[0] = en[0] ? in_valid : v_r[0];
    for (int i = 1; i < N; i++) begin
      v_nxt[i] = en[i] ? v_r[i-1] : v_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[N-1];

  hcfp_front u_front (
    .clk      (clk),
    .en       (en[0]),
    .in_data  (in_data),
    .origin_x (origin_x_r),
    .origin_y (origin_y_r),
    .side     (side_r),
    .dmul     (dmul),
    .q_r      (div_q[0])
  );

  // Quotient bits, most significant first
  for (genvar g = 0; g < hcfp_pkg::DIV_STEPS; g++) begin : g_div
    hcfp_div_step u_step (
      .clk     (clk),
      .en      (en[g+1]),
      .bit_idx (3'(hcfp_pkg::DIV_STEPS - 1 - g)),
      .side    (side_r),
      .dmul    (dmul),
      .d       (div_q[g]),
      .q_r     (div_q[g+1])
    );
  end

  hcfp_zone u_zone (
    .clk        (clk),
    .en_a       (en[hcfp_pkg::DIV_STEPS+1]),
    .en_b       (en[hcfp_pkg::DIV_STEPS+2]),
    .dmul       (dmul),
    .rows       (rows_sat),
    .cols       (cols_sat),
    .first_long (first_long_r),
    .d          (div_q[hcfp_pkg::DIV_STEPS]),
    .q_r        (sel_q)
  );

  hcfp_index u_index (
    .clk        (clk),
    .en         (en[N-1]),
    .cols       (cols_sat),
    .first_long (first_long_r),
    .d          (sel_q),
    .q_r        (out_data)
  );

  // A miss carries cleared fields
  `HCFP_ASSERT_NOW(a_miss_zero, out_valid && !out_data.hit,
    out_data.cell_index == 12'd0 && out_data.cell_row == 6'd0 && out_data.cell_column == 6'd0,
    "miss with non-zero fields")
  // A hit row lies inside the grid
  `HCFP_ASSERT_NOW(a_row_range, out_valid && out_data.hit,
    {1'b0, out_data.cell_row} < rows_sat, "hit row beyond row count")
  // A hit column lies inside a long row
  `HCFP_ASSERT_NOW(a_col_range, out_valid && out_data.hit,
    {1'b0, out_data.cell_column} < cols_sat, "hit column beyond row length")
  // The entry stage fills only from an accepted transaction
  `HCFP_ASSERT_NEXT(a_fill_src, !v_r[0] && !(in_valid && in_ready),
    !v_r[0], "entry stage filled without a transaction")

endmodule
`default_nettype wire

// File: tb/hex_cell_checker.sv
// Checker for the hexagon cell lookup: predicts each result and compares it
`timescale 1ns / 1ps
module hex_cell_checker (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_ready,
  input  hcfp_pkg::in_t  in_data,
  input  logic           out_valid,
  input  logic           out_ready,
  input  hcfp_pkg::out_t out_data,
  input  logic           cfg_we,
  input  logic [2:0]     cfg_index,
  input  logic [15:0]    cfg_wdata,
  output int             fail_count,
  output int             pending,
  output int             hits_seen,
  output int             results_seen
);

  // Shadow copy of the grid registers
  logic signed [11:0] grid_ox, grid_oy;
  logic [15:0]        grid_side;
  logic [6:0]         grid_rows, grid_cells;
  logic               grid_first_long;

  hcfp_pkg::out_t cells_due[$];

  function automatic bit short_row(input longint r);
    return (grid_first_long != 1'b0) != ((r & 1) == 0);
  endfunction

  // Work out the cell under one point
  function automatic hcfp_pkg::out_t locate_cell(input hcfp_pkg::in_t p);
    hcfp_pkg::out_t res;
    longint dx, dy, side, rows, cols, h, k, b, row, col, ncells, idx;
    longint left2, top2, bot2;
    bit     top_hit, bot_hit;
    res  = '0;
    dx   = longint'(p.point_x) - longint'(grid_ox);
    dy   = longint'(p.point_y) - longint'(grid_oy);
    side = grid_side;
    rows = (grid_rows > 64) ? 64 : grid_rows;
    cols = (grid_cells > 64) ? 64 : grid_cells;
    if (side == 0 || dx < 0 || dy < 0) return res;
    h = (dy * 512) / side;
    k = (dx * 64'd8388608) / (28378 * side);
    b = h / 3;
    if (h % 3 == 0) begin
      left2   = dx * 8388608 - k * 28378 * side;
      top2    = 512 * dy - 3 * b * side;
      bot2    = 3 * b * side + side - 512 * dy;
      top_hit = top2 * 28378 > left2;
      bot_hit = bot2 * 28378 > left2;
      if (short_row(b)) begin
        if ((k & 1) == 0) begin
          if (top_hit) begin row = b; col = k / 2 - 1; end
          else begin row = b - 1; col = k / 2; end
        end else begin
          if (bot_hit) row = b - 1; else row = b;
          col = k / 2;
        end
      end else begin
        if ((k & 1) == 0) begin
          if (bot_hit) begin row = b - 1; col = k / 2 - 1; end
          else begin row = b; col = k / 2; end
        end else begin
          if (top_hit) row = b; else row = b - 1;
          col = k / 2;
        end
      end
    end else begin
      row = b;
      if (row >= rows) return res;
      if (short_row(row)) begin
        if (k < 1) return res;
        col = (k - 1) / 2;
      end else begin
        col = k / 2;
      end
    end
    if (row < 0 || row >= rows || col < 0) return res;
    ncells = short_row(row) ? cols - 1 : cols;
    if (col >= ncells) return res;
    idx = (2 * cols - 1) * (row / 2) + col;
    if (row & 1) idx += grid_first_long ? cols : cols - 1;
    res.hit         = 1'b1;
    res.cell_index  = idx[11:0];
    res.cell_row    = row[5:0];
    res.cell_column = col[5:0];
    return res;
  endfunction

  assign pending = cells_due.size();

  // Track registers, queue predictions and compare results
  always @(posedge clk) begin
    hcfp_pkg::out_t want;
    if (!rst_n) begin
      grid_ox <= '0; grid_oy <= '0; grid_side <= 16'd5120;
      grid_rows <= 7'd8; grid_cells <= 7'd8; grid_first_long <= 1'b0;
      cells_due.delete();
      fail_count <= 0; hits_seen <= 0; results_seen <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          hcfp_pkg::REG_ORIGIN_X:       grid_ox <= cfg_wdata[11:0];
          hcfp_pkg::REG_ORIGIN_Y:       grid_oy <= cfg_wdata[11:0];
          hcfp_pkg::REG_SIDE_LENGTH:    grid_side <= cfg_wdata;
          hcfp_pkg::REG_ROW_COUNT:      grid_rows <= cfg_wdata[6:0];
          hcfp_pkg::REG_LONG_ROW_CELLS: grid_cells <= cfg_wdata[6:0];
          hcfp_pkg::REG_FIRST_ROW_LONG: grid_first_long <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) cells_due.push_back(locate_cell(in_data));
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (cells_due.size() == 0) begin
          $error("unexpected result transaction %p", out_data);
          fail_count <= fail_count + 1;
        end else begin
          want = cells_due.pop_front();
          if (want.hit) hits_seen <= hits_seen + 1;
          if (want != out_data) begin
            fail_count <= fail_count + 1;
            if (want.hit != out_data.hit)
              $error("hit: expected %0d actual %0d", want.hit, out_data.hit);
            if (want.cell_index != out_data.cell_index)
              $error("cell_index: expected %0d actual %0d",
                     want.cell_index, out_data.cell_index);
            if (want.cell_row != out_data.cell_row)
              $error("cell_row: expected %0d actual %0d",
                     want.cell_row, out_data.cell_row);
            if (want.cell_column != out_data.cell_column)
              $error("cell_column: expected %0d actual %0d",
                     want.cell_column, out_data.cell_column);
          end
        end
      end
    end
  end
endmodule

// File: tb/testbench.sv
// Top of the hexagon cell lookup testbench: stimulus, pacing and verdict
`timescale 1ns / 1ps
module testbench;

  localparam int PIPE_CYCLES = 12;
  localparam int STALL_LIMIT = 4000;

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           in_valid = 1'b0;
  logic           in_ready;
  hcfp_pkg::in_t  in_data = '0;
  logic           out_valid;
  logic           out_ready = 1'b0;
  hcfp_pkg::out_t out_data;
  logic           cfg_we = 1'b0;
  logic [2:0]     cfg_index = hcfp_pkg::REG_ORIGIN_X;
  logic [15:0]    cfg_wdata = '0;
  int          fail_count, pending, hits_seen, results_seen;
  int          offer_pct = 100;
  int          accept_pct = 100;
  int          hold_off = 0;
  int          quiet_cycles = 0;
  int          points_sent = 0;
  logic [15:0] cur_side = 16'd5120;
  logic signed [11:0] cur_ox = '0, cur_oy = '0;

  always #5 clk = ~clk;

  hex_cell_from_point u_dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready,
    .out_data, .cfg_we, .cfg_index, .cfg_wdata
  );

  hex_cell_checker u_chk (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready,
    .out_data, .cfg_we, .cfg_index, .cfg_wdata,
    .fail_count, .pending, .hits_seen, .results_seen
  );

  // Randomly stall the result side, or hold off for a counted stretch
  always @(posedge clk) begin
    if (hold_off > 0) begin
      out_ready <= 1'b0;
      hold_off  <= hold_off - 1;
    end else begin
      out_ready <= ($urandom_range(99) < accept_pct);
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout with %0d results outstanding", pending);
      $display("status: fail");
      $finish;
    end
  end

  // Offer one point; valid stays up into the next transaction when there is no gap
  task automatic send_point(input logic signed [11:0] px, input logic signed [11:0] py);
    while ($urandom_range(99) >= offer_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{point_x: px, point_y: py};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    points_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (PIPE_CYCLES + 2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == hcfp_pkg::REG_SIDE_LENGTH) cur_side = val;
    if (idx == hcfp_pkg::REG_ORIGIN_X) cur_ox = val[11:0];
    if (idx == hcfp_pkg::REG_ORIGIN_Y) cur_oy = val[11:0];
  endtask

  task automatic set_grid(input logic signed [11:0] ox, input logic signed [11:0] oy,
                          input logic [15:0] side, input logic [6:0] rows,
                          input logic [6:0] cells, input logic first_long);
    drain_results();
    write_reg(hcfp_pkg::REG_ORIGIN_X, {{4{ox[11]}}, ox});
    write_reg(hcfp_pkg::REG_ORIGIN_Y, {{4{oy[11]}}, oy});
    write_reg(hcfp_pkg::REG_SIDE_LENGTH, side);
    write_reg(hcfp_pkg::REG_ROW_COUNT, {9'd0, rows});
    write_reg(hcfp_pkg::REG_LONG_ROW_CELLS, {9'd0, cells});
    write_reg(hcfp_pkg::REG_FIRST_ROW_LONG, {15'd0, first_long});
  endtask

  // Mostly points over the grid near band edges, some anywhere
  task automatic random_point();
    int span, dx, dy;
    span = (cur_side >> 8) * 2 * 66 + 8;
    if ($urandom_range(9) < 2) begin
      send_point(12'($urandom), 12'($urandom));
    end else begin
      dx = $urandom_range(span) - 4;
      dy = $urandom_range(span) - 4;
      if ($urandom_range(1)) dy = ((dy * 2 / (cur_side >> 8 | 1)) * (cur_side >> 8)) / 2;
      dx += cur_ox;
      dy += cur_oy;
      if (dx > 2047) dx = 2047 - $urandom_range(3);
      if (dy > 2047) dy = 2047 - $urandom_range(3);
      send_point(dx[11:0], dy[11:0]);
    end
  endtask

  task automatic random_phase(input int count, input int offer, input int accept);
    offer_pct  = offer;
    accept_pct = accept;
    repeat (count) random_point();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset settings, corners, origin, band edges
    send_point(12'sd0, 12'sd0);
    send_point(-12'sd1, 12'sd5);
    send_point(12'sd5, -12'sd1);
    send_point(12'sd2047, 12'sd2047);
    send_point(-12'sd2048, -12'sd2048);
    send_point(12'sd2047, -12'sd2048);
    send_point(12'sd17, 12'sd10);
    send_point(12'sd1, 12'sd1);
    send_point(12'sd35, 12'sd30);
    send_point(12'sd40, 12'sd60);
    send_point(12'sd130, 12'sd175);
    send_point(12'sd100, 12'sd300);
    set_grid(12'sd0, 12'sd0, 16'd0, 7'd8, 7'd8, 1'b1);
    send_point(12'sd10, 12'sd10);
    set_grid(12'sd10, -12'sd20, 16'd256, 7'd127, 7'd127, 1'b1);
    send_point(12'sd20, 12'sd0);
    send_point(12'sd120, 12'sd80);
    send_point(12'sd9, 12'sd30);
    set_grid(-12'sd2048, 12'sd2047, 16'd65535, 7'd1, 7'd1, 1'b0);
    send_point(12'sd0, 12'sd2047);
    send_point(-12'sd2048, 12'sd2047);
    set_grid(12'sd0, 12'sd0, 16'd1024, 7'd4, 7'd0, 1'b0);
    send_point(12'sd3, 12'sd10);
    send_point(12'sd10, 12'sd1);

    // Random phases under several grids and pacing patterns
    set_grid(12'sd0, 12'sd0, 16'd2560, 7'd64, 7'd64, 1'b0);
    random_phase(200, 100, 100);
    set_grid(-12'sd300, 12'sd100, 16'd1000, 7'd20, 7'd12, 1'b1);
    random_phase(200, 39, 100);
    set_grid(12'sd5, -12'sd7, 16'd256, 7'd64, 7'd64, 1'b1);
    random_phase(200, 100, 39);
    set_grid(12'sd50, 12'sd50, 16'd4000, 7'd9, 7'd2, 1'b0);
    random_phase(200, 71, 71);

    // Hold the result side off while points keep coming
    set_grid(12'sd0, 12'sd0, 16'd3000, 7'd30, 7'd20, 1'b1);
    offer_pct = 100;
    hold_off <= 200;
    repeat (60) random_point();
    drain_results();

    set_grid(12'sd0, 12'sd0, 16'd65535, 7'd64, 7'd64, 1'b0);
    random_phase(100, 100, 100);
    set_grid(12'sd100, 12'sd0, 16'd777, 7'd33, 7'd5, 1'b1);
    random_phase(200, 39, 39);
    set_grid(-12'sd2048, -12'sd2048, 16'd5120, 7'd64, 7'd64, 1'b0);
    random_phase(200, 100, 100);
    set_grid(12'sd0, 12'sd0, 16'd1280, 7'd10, 7'd10, 1'b1);
    random_phase(170, 71, 39);

    offer_pct  = 100;
    accept_pct = 100;
    drain_results();
    repeat (2) @(posedge clk);

    $display("%0d points sent across many grid settings and pacing mixes,", points_sent);
    $display("%0d results checked, %0d of them hits", results_seen, hits_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
